// File: src/upps_pkg.sv
// Shared types and constants for the UPS power path supervisor.
`timescale 1ns / 1ps

package upps_pkg;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_DIV_CHK,
        ST_DIV,
        ST_DONE
    } state_t;

    // Converter channel tags
    typedef enum logic [2:0] {
        CH_REF       = 3'd0,
        CH_BATTERY   = 3'd1,
        CH_RAIL      = 3'd2,
        CH_AUX1      = 3'd3,
        CH_AUX2      = 3'd4,
        CH_FIVE_VOLT = 3'd5,
        CH_AUX_OUT   = 3'd6,
        CH_CURRENT   = 3'd7
    } chan_t;

    // Source codes for rail and power selection
    typedef enum logic [1:0] {
        SRC_NONE = 2'd0,
        SRC_BATT = 2'd1,
        SRC_AUX1 = 2'd2,
        SRC_AUX2 = 2'd3
    } src_t;

    // Configuration register file
    localparam int unsigned NUM_CFG   = 8;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned WORD_W    = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_LOW_CUT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_RECOVER = 3'd7;

    localparam logic [WORD_W-1:0] CFG_RESET [NUM_CFG] = '{
        16'd1000, 16'd1000, 16'd1000, 16'd1000,
        16'd1000, 16'd1000, 16'd6000, 16'd6500
    };

    // Scaling constants
    localparam int unsigned T_W      = 12;
    localparam int unsigned CUR_K_W  = 24;
    localparam int unsigned DIV_K_W  = 10;
    localparam int unsigned MUL_W    = 16;
    localparam int unsigned CNT_W    = 4;

    localparam logic [T_W-1:0]     VREF_MV     = 12'd3300;
    localparam logic [10:0]        BANDGAP_MV  = 11'd1100;
    // 3300 mV reference times the 3333 current gain
    localparam logic [CUR_K_W-1:0] CUR_K       = 24'd10998900;
    localparam logic [DIV_K_W-1:0] DIV_K       = 10'd1000;
    localparam logic [WORD_W:0]    CHG_MARGIN  = 17'd1000;
    localparam logic [WORD_W-1:0]  MAX_VAL     = 16'hFFFF;
    localparam logic [CNT_W-1:0]   WORD_STEPS  = 4'd15;

endpackage

// File: src/ups_power_path_supervisor.sv
// Top level of the UPS power path supervisor: sample scaling and status update.
`timescale 1ns / 1ps
// The reference channel goes straight to the divide check, the current channel passes one
// multiply phase and other voltages two; a result that saturates skips the divider.
// Phases run on a bit-serial shift-add multiplier (one multiplier bit per cycle) and a 16-step
// restoring divider (one quotient bit per cycle).
// One item is in work at a time; a new one is taken only after the result is registered.
// Synchronous active-low reset restores the register defaults and clears the kept readings, status and output valid.

module ups_power_path_supervisor
    import upps_pkg::*;
#(
    parameter int unsigned SAMPLE_BITS = 10
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration write port
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [WORD_W-1:0]      cfg_data,
    // sample input
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [2:0]             s_channel,
    input  logic [SAMPLE_BITS-1:0] s_sample,
    // result output
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [2:0]             m_channel_echo,
    output logic [WORD_W-1:0]      m_value,
    output logic                   m_saturated,
    output logic                   m_battery_good,
    output logic                   m_charge_on,
    output logic                   m_battery_on,
    output logic [1:0]             m_rail_source,
    output logic [1:0]             m_power_source
);

    localparam int unsigned ACC_W = CUR_K_W + SAMPLE_BITS;
    localparam int unsigned HI_W  = ACC_W - WORD_W;
    localparam int unsigned DIV_W = (SAMPLE_BITS > DIV_K_W) ? SAMPLE_BITS : DIV_K_W;

    // Sequencer and datapath registers
    state_t                   state_reg, state_next;
    chan_t                    ch_reg, ch_next;
    logic [SAMPLE_BITS-1:0]   smp_reg, smp_next;
    logic [ACC_W-1:0]         acc_reg, acc_next;
    logic [MUL_W-1:0]         mul_reg, mul_next;
    logic [T_W-1:0]           t_reg, t_next;
    logic [DIV_W-1:0]         rem_reg, rem_next;
    logic [WORD_W-1:0]        qn_reg, qn_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     sat_reg, sat_next;

    // Configuration and kept readings
    logic [WORD_W-1:0]        cfg_reg [NUM_CFG];
    logic [WORD_W-1:0]        battery_mv_reg, battery_mv_next;
    logic [WORD_W-1:0]        rail_mv_reg, rail_mv_next;
    logic [WORD_W-1:0]        aux1_mv_reg, aux1_mv_next;
    logic [WORD_W-1:0]        aux2_mv_reg, aux2_mv_next;

    // Status
    logic                     good_reg, good_next;
    logic                     charging_reg, charging_next;
    logic                     batt_en_reg, batt_en_next;
    src_t                     rail_from_reg, rail_from_next;
    src_t                     powered_reg, powered_next;

    // Output register
    logic                     m_valid_reg, m_valid_next;
    logic [2:0]               m_ch_reg, m_ch_next;
    logic [WORD_W-1:0]        m_value_reg, m_value_next;
    logic                     m_sat_reg, m_sat_next;
    logic                     m_good_reg, m_good_next;
    logic                     m_chg_reg, m_chg_next;
    logic                     m_batt_reg, m_batt_next;
    src_t                     m_rail_reg, m_rail_next;
    src_t                     m_pow_reg, m_pow_next;

    // Datapath nets
    logic [DIV_W-1:0]         divisor;
    logic [WORD_W-1:0]        factor;
    logic [ACC_W-1:0]         addend;
    logic [ACC_W-1:0]         mul_sum;
    logic [ACC_W-1:0]         mul_scaled;
    logic [HI_W-1:0]          acc_hi;
    logic                     hi_big;
    logic [DIV_W:0]           div_trial;
    logic                     div_ge;
    logic [DIV_W:0]           div_diff;
    logic [WORD_W-1:0]        result;
    logic                     out_free;

    // Status update nets
    logic                     good_upd;
    logic                     rail_gt_chg;
    logic                     ext1;
    logic                     en1;
    src_t                     rail1;
    logic                     chg2;
    logic                     en2;
    src_t                     rail_upd;
    src_t                     pow_upd;

    // Select divisor, factor and multiplier addend
    assign divisor  = (ch_reg == CH_REF) ? DIV_W'(smp_reg) : DIV_W'(DIV_K);
    assign factor   = cfg_reg[CFG_IDX_W'(ch_reg) - CFG_IDX_W'(1)];
    assign addend   = (state_reg == ST_MUL_A)
                    ? ((ch_reg == CH_CURRENT) ? ACC_W'(CUR_K) : ACC_W'(VREF_MV))
                    : ACC_W'(t_reg);

    // One multiplier bit per cycle, MSB first
    assign mul_sum    = {acc_reg[ACC_W-2:0], 1'b0} + (mul_reg[MUL_W-1] ? addend : '0);
    assign mul_scaled = mul_sum >> SAMPLE_BITS;

    // Quotient fits 16 bits only when the upper part is below the divisor
    assign acc_hi = acc_reg[ACC_W-1:WORD_W];
    assign hi_big = acc_hi >= HI_W'(divisor);

    // One restoring division step
    assign div_trial = {rem_reg, qn_reg[WORD_W-1]};
    assign div_ge    = div_trial >= (DIV_W+1)'(divisor);
    assign div_diff  = div_trial - (DIV_W+1)'(divisor);

    assign result   = sat_reg ? MAX_VAL : qn_reg;
    assign out_free = !m_valid_reg || m_ready;

    // Battery hysteresis, charge choice, rail and power source selection
    always_comb begin
        good_upd    = good_reg ? !(battery_mv_reg < cfg_reg[CFG_LOW_CUT])
                               : (battery_mv_reg > cfg_reg[CFG_RECOVER]);
        rail_gt_chg = {1'b0, rail_mv_reg} > ({1'b0, battery_mv_reg} + CHG_MARGIN);
        ext1        = (rail_from_reg == SRC_AUX1) || (rail_from_reg == SRC_AUX2);
        en1         = !(ext1 && rail_gt_chg) && good_upd;
        if (en1 && (aux2_mv_reg < rail_mv_reg)) begin
            rail1 = SRC_BATT;
        end else if (aux2_mv_reg > aux1_mv_reg) begin
            rail1 = SRC_AUX2;
        end else begin
            rail1 = SRC_AUX1;
        end
        chg2 = (rail1 != SRC_BATT) && rail_gt_chg;
        en2  = !chg2 && good_upd;
        if (rail_mv_reg > battery_mv_reg) begin
            rail_upd = rail1;
            pow_upd  = rail1;
        end else begin
            rail_upd = SRC_BATT;
            pow_upd  = powered_reg;
        end
    end

    // Next state and datapath
    always_comb begin
        state_next      = state_reg;
        ch_next         = ch_reg;
        smp_next        = smp_reg;
        acc_next        = acc_reg;
        mul_next        = mul_reg;
        t_next          = t_reg;
        rem_next        = rem_reg;
        qn_next         = qn_reg;
        cnt_next        = cnt_reg;
        sat_next        = sat_reg;
        battery_mv_next = battery_mv_reg;
        rail_mv_next    = rail_mv_reg;
        aux1_mv_next    = aux1_mv_reg;
        aux2_mv_next    = aux2_mv_reg;
        good_next       = good_reg;
        charging_next   = charging_reg;
        batt_en_next    = batt_en_reg;
        rail_from_next  = rail_from_reg;
        powered_next    = powered_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_ch_next       = m_ch_reg;
        m_value_next    = m_value_reg;
        m_sat_next      = m_sat_reg;
        m_good_next     = m_good_reg;
        m_chg_next      = m_chg_reg;
        m_batt_next     = m_batt_reg;
        m_rail_next     = m_rail_reg;
        m_pow_next      = m_pow_reg;
        s_ready         = 1'b0;

        case (state_reg)
            // Take an item and load the first phase
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ch_next  = chan_t'(s_channel);
                    smp_next = s_sample;
                    if (chan_t'(s_channel) == CH_REF) begin
                        acc_next   = ACC_W'(BANDGAP_MV) << SAMPLE_BITS;
                        state_next = ST_DIV_CHK;
                    end else begin
                        acc_next   = '0;
                        mul_next   = MUL_W'(s_sample) << (MUL_W - SAMPLE_BITS);
                        cnt_next   = CNT_W'(SAMPLE_BITS - 1);
                        state_next = ST_MUL_A;
                    end
                end
            end

            // Multiply the sample by the channel constant, then drop full scale
            ST_MUL_A: begin
                acc_next = mul_sum;
                mul_next = mul_reg << 1;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    if (ch_reg == CH_CURRENT) begin
                        acc_next   = mul_scaled;
                        state_next = ST_DIV_CHK;
                    end else begin
                        t_next     = T_W'(mul_scaled);
                        acc_next   = '0;
                        mul_next   = factor;
                        cnt_next   = WORD_STEPS;
                        state_next = ST_MUL_B;
                    end
                end
            end

            // Multiply the millivolt reading by the divider factor
            ST_MUL_B: begin
                acc_next = mul_sum;
                mul_next = mul_reg << 1;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    state_next = ST_DIV_CHK;
                end
            end

            // Flag overflow or zero divisor, else seed the divider
            ST_DIV_CHK: begin
                if (hi_big) begin
                    sat_next   = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    sat_next   = 1'b0;
                    rem_next   = DIV_W'(acc_hi);
                    qn_next    = acc_reg[WORD_W-1:0];
                    cnt_next   = WORD_STEPS;
                    state_next = ST_DIV;
                end
            end

            // Develop one quotient bit per cycle
            ST_DIV: begin
                rem_next = div_ge ? DIV_W'(div_diff) : DIV_W'(div_trial);
                qn_next  = {qn_reg[WORD_W-2:0], div_ge};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    state_next = ST_DONE;
                end
            end

            // Store the reading, update status and hand the item out
            ST_DONE: begin
                if (out_free) begin
                    case (ch_reg)
                        CH_BATTERY: battery_mv_next = result;
                        CH_RAIL:    rail_mv_next    = result;
                        CH_AUX1:    aux1_mv_next    = result;
                        CH_AUX2:    aux2_mv_next    = result;
                        default: ;
                    endcase
                    m_good_next = good_reg;
                    m_chg_next  = charging_reg;
                    m_batt_next = batt_en_reg;
                    m_rail_next = rail_from_reg;
                    m_pow_next  = powered_reg;
                    if (ch_reg == CH_CURRENT) begin
                        good_next      = good_upd;
                        charging_next  = chg2;
                        batt_en_next   = en2;
                        rail_from_next = rail_upd;
                        powered_next   = pow_upd;
                        m_good_next    = good_upd;
                        m_chg_next     = chg2;
                        m_batt_next    = en2;
                        m_rail_next    = rail_upd;
                        m_pow_next     = pow_upd;
                    end
                    m_valid_next = 1'b1;
                    m_ch_next    = ch_reg;
                    m_value_next = result;
                    m_sat_next   = sat_reg;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register and control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            battery_mv_reg <= '0;
            rail_mv_reg    <= '0;
            aux1_mv_reg    <= '0;
            aux2_mv_reg    <= '0;
            good_reg       <= 1'b0;
            charging_reg   <= 1'b0;
            batt_en_reg    <= 1'b0;
            rail_from_reg  <= SRC_NONE;
            powered_reg    <= SRC_NONE;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            battery_mv_reg <= battery_mv_next;
            rail_mv_reg    <= rail_mv_next;
            aux1_mv_reg    <= aux1_mv_next;
            aux2_mv_reg    <= aux2_mv_next;
            good_reg       <= good_next;
            charging_reg   <= charging_next;
            batt_en_reg    <= batt_en_next;
            rail_from_reg  <= rail_from_next;
            powered_reg    <= powered_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        ch_reg      <= ch_next;
        smp_reg     <= smp_next;
        acc_reg     <= acc_next;
        mul_reg     <= mul_next;
        t_reg       <= t_next;
        rem_reg     <= rem_next;
        qn_reg      <= qn_next;
        cnt_reg     <= cnt_next;
        sat_reg     <= sat_next;
        m_ch_reg    <= m_ch_next;
        m_value_reg <= m_value_next;
        m_sat_reg   <= m_sat_next;
        m_good_reg  <= m_good_next;
        m_chg_reg   <= m_chg_next;
        m_batt_reg  <= m_batt_next;
        m_rail_reg  <= m_rail_next;
        m_pow_reg   <= m_pow_next;
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CFG; i++) begin
                cfg_reg[i] <= CFG_RESET[i];
            end
        end else if (cfg_we) begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_channel_echo = m_ch_reg;
    assign m_value        = m_value_reg;
    assign m_saturated    = m_sat_reg;
    assign m_battery_good = m_good_reg;
    assign m_charge_on    = m_chg_reg;
    assign m_battery_on   = m_batt_reg;
    assign m_rail_source  = m_rail_reg;
    assign m_power_source = m_pow_reg;

endmodule
